/* rtl/i2c_register_master_assert.svh */
// Assertion macros for the register master.
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IRM_ASSERT_IMPL(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("i2c_register_master: label failed");
`define IRM_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("i2c_register_master: label failed");
`else
`define IRM_ASSERT_IMPL(label, a, c)
`define IRM_ASSERT_NEXT(label, a, c)
`endif
`endif

/* rtl/irm_pkg.sv */
package irm_pkg;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_HDR_W, PH_LO_W, PH_REG, PH_RESTART,
    PH_HDR_R, PH_WAIT, PH_WDATA, PH_RDATA, PH_STOP
  } phase_t;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_SUPPLY = 2'd3;

  localparam logic [2:0] CFG_DEV_ADDR = 3'd0;
  localparam logic [2:0] CFG_TEN_BIT  = 3'd1;
  localparam logic [2:0] CFG_LSB      = 3'd2;
  localparam logic [2:0] CFG_REG_BE   = 3'd3;
  localparam logic [2:0] CFG_DATA_BE  = 3'd4;
  localparam logic [2:0] CFG_DUMMY    = 3'd5;
  localparam logic [2:0] CFG_REG_LEN  = 3'd6;
  localparam logic [2:0] CFG_DATA_LEN = 3'd7;

  localparam logic [7:0] TEN_BIT_HDR = 8'hF0;

  typedef struct packed {
    logic [9:0] dev_addr;
    logic       ten_bit;
    logic       lsb_first;
    logic       reg_be;
    logic       data_be;
    logic       dummy;
    logic [2:0] reg_len;
    logic [2:0] word_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        sda_level;
    logic [31:0] reg_address;
    logic [15:0] word_count;
    logic [31:0] write_word;
  } item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_drive;
    logic        busy_res;
    logic        word_request;
    logic [31:0] read_word;
    logic        read_valid;
    logic        done_res;
    logic [15:0] words_done;
    logic        nack_seen;
  } res_t;

endpackage

/* rtl/i2c_register_master.sv */
// I2C register master. Each input beat is one command or one bus tick: begin
// write, begin read, supply a write word, or tick. Every beat yields exactly
// one result beat with the pin drives (scl_level, sda_drive) and status after
// that beat. A two-entry queue separates the input side from the bus engine,
// which sequences one micro-step per beat, so a new beat is accepted every
// cycle while the result register drains; sustained rate is one beat per
// cycle while the output does not stall. An input beat passes the queue,
// then the result register. Configuration must be written through the cfg
// port while idle (unenforced); a 10-bit address uses 0xF0 header framing.
module i2c_register_master
  import irm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic        sda_level,
  input  logic [31:0] reg_address,
  input  logic [15:0] word_count,
  input  logic [31:0] write_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_level,
  output logic        sda_drive,
  output logic        busy_res,
  output logic        word_request,
  output logic [31:0] read_word,
  output logic        read_valid,
  output logic        done_res,
  output logic [15:0] words_done,
  output logic        nack_seen
);
  cfg_t cfg;
  item_t in_item, q_item;
  res_t res;
  logic q_full, q_valid, q_take;

  assign cfg_ready = 1'b1;

  // Register file: apply each cfg beat at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{dev_addr: 10'd0, ten_bit: 1'b0, lsb_first: 1'b0, reg_be: 1'b0,
               data_be: 1'b0, dummy: 1'b1, reg_len: 3'd1, word_bytes: 3'd1};
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEV_ADDR: cfg.dev_addr <= cfg_data[9:0];
        CFG_TEN_BIT:  cfg.ten_bit <= cfg_data[0];
        CFG_LSB:      cfg.lsb_first <= cfg_data[0];
        CFG_REG_BE:   cfg.reg_be <= cfg_data[0];
        CFG_DATA_BE:  cfg.data_be <= cfg_data[0];
        CFG_DUMMY:    cfg.dummy <= cfg_data[0];
        CFG_REG_LEN:  cfg.reg_len <= cfg_data[2:0];
        CFG_DATA_LEN: cfg.word_bytes <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{opcode: opcode, sda_level: sda_level, reg_address: reg_address,
                     word_count: word_count, write_word: write_word};
  // Hold off the source while the queue is full.
  assign in_stall = q_full;

  irm_fifo #(.DEPTH(2)) u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(in_valid), .wr_full(q_full), .wr_data(in_item),
    .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_item)
  );

  irm_engine u_engine (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(q_valid), .in_take(q_take), .item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign scl_level = res.scl_level;
  assign sda_drive = res.sda_drive;
  assign busy_res = res.busy_res;
  assign word_request = res.word_request;
  assign read_word = res.read_word;
  assign read_valid = res.read_valid;
  assign done_res = res.done_res;
  assign words_done = res.words_done;
  assign nack_seen = res.nack_seen;

`include "i2c_register_master_assert.svh"

  `IRM_ASSERT_IMPL(a_read_word_zero, out_valid && !read_valid, read_word == 32'd0)
  `IRM_ASSERT_IMPL(a_done_idle, out_valid && done_res, !busy_res)
  `IRM_ASSERT_IMPL(a_req_busy, out_valid && word_request, busy_res)
  `IRM_ASSERT_NEXT(a_res_hold, out_valid && out_stall, out_valid)
endmodule

/* rtl/irm_fifo.sv */
module irm_fifo import irm_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_full,
  input  item_t wr_data,
  output logic  rd_valid,
  input  logic  rd_take,
  output item_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  item_t mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;
  logic push, pop;

  assign wr_full  = (count == (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign push = wr_valid && !wr_full;
  assign pop  = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* rtl/irm_engine.sv */
module irm_engine import irm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_take,
  input  item_t item,
  output logic  out_valid,
  input  logic  out_stall,
  output res_t  res
);
  phase_t phase;
  logic [3:0] bit_index;
  logic [2:0] sub_step;
  logic [2:0] byte_index;
  logic [15:0] word_index, count_hold;
  logic [7:0] shift_byte;
  logic [31:0] word_buffer, address_hold;
  logic is_read, abort_flag, scl_pin, sda_pin;

  phase_t phase_next;
  logic [3:0] bit_index_next;
  logic [2:0] sub_step_next, byte_index_next;
  logic [15:0] word_index_next, count_hold_next;
  logic [7:0] shift_byte_next;
  logic [31:0] word_buffer_next, address_hold_next;
  logic is_read_next, abort_flag_next, scl_next, sda_next;
  logic valid_c, done_c;
  logic [31:0] word_c;

  logic [2:0] rlen, dlen;
  assign rlen = (cfg.reg_len > 3'd4) ? 3'd4 : cfg.reg_len;
  assign dlen = (cfg.word_bytes == 3'd0) ? 3'd1 :
                (cfg.word_bytes > 3'd4) ? 3'd4 : cfg.word_bytes;

  // Result register holds until the consumer takes it.
  assign in_take = in_valid && (!out_valid || !out_stall);

  function automatic logic [7:0] header(input cfg_t c, input logic rw);
    if (c.ten_bit) begin
      return TEN_BIT_HDR | {5'd0, c.dev_addr[9:8], rw};
    end
    return {c.dev_addr[6:0], rw};
  endfunction

  function automatic logic [4:0] bpos(input logic [2:0] i, input logic [2:0] n,
                                      input logic big);
    logic [2:0] k;
    k = big ? (n - 3'd1 - i) : i;
    return {k[1:0], 3'b000};
  endfunction

  always_comb begin
    logic [2:0] i;
    logic [7:0] rbyte;
    logic last;
    logic [2:0] bi;
    logic [15:0] wi;
    logic [3:0] sel;
    phase_t tgt;
    logic do_go;
    phase_next = phase;
    bit_index_next = bit_index;
    sub_step_next = sub_step;
    byte_index_next = byte_index;
    word_index_next = word_index;
    count_hold_next = count_hold;
    shift_byte_next = shift_byte;
    word_buffer_next = word_buffer;
    address_hold_next = address_hold;
    is_read_next = is_read;
    abort_flag_next = abort_flag;
    scl_next = scl_pin;
    sda_next = sda_pin;
    valid_c = 1'b0;
    done_c = 1'b0;
    word_c = '0;
    do_go = 1'b0;
    tgt = PH_IDLE;
    i = '0;
    rbyte = '0;
    last = 1'b0;
    bi = '0;
    wi = '0;
    sel = '0;
    if (phase == PH_IDLE) begin
      if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
        is_read_next = (item.opcode == OP_READ);
        address_hold_next = item.reg_address;
        count_hold_next = item.word_count;
        word_index_next = '0;
        byte_index_next = '0;
        word_buffer_next = '0;
        abort_flag_next = 1'b0;
        do_go = 1'b1;
        tgt = PH_START;
      end
    end else if (phase == PH_WAIT) begin
      if (item.opcode == OP_SUPPLY) begin
        word_buffer_next = item.write_word;
        byte_index_next = '0;
        do_go = 1'b1;
        tgt = PH_WDATA;
      end
    end else if (item.opcode == OP_TICK) begin
      case (phase)
        PH_START, PH_RESTART: begin
          case (sub_step)
            3'd0: sda_next = 1'b1;
            3'd1: scl_next = 1'b1;
            3'd2: sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
          if (sub_step >= 3'd3) begin
            do_go = 1'b1;
            if (phase == PH_RESTART ||
                (is_read && !cfg.dummy && !cfg.ten_bit)) begin
              tgt = PH_HDR_R;
            end else begin
              tgt = PH_HDR_W;
            end
          end else begin
            sub_step_next = sub_step + 3'd1;
          end
        end
        PH_STOP: begin
          case (sub_step)
            3'd0: scl_next = 1'b0;
            3'd1: sda_next = 1'b0;
            3'd2: scl_next = 1'b1;
            default: sda_next = 1'b1;
          endcase
          if (sub_step >= 3'd3) begin
            do_go = 1'b1;
            tgt = PH_IDLE;
            done_c = 1'b1;
          end else begin
            sub_step_next = sub_step + 3'd1;
          end
        end
        PH_RDATA: begin
          if (bit_index == 4'd0) begin
            sda_next = 1'b1;
            bit_index_next = 4'd1;
            sub_step_next = '0;
          end else if (bit_index <= 4'd8) begin
            if (sub_step == 3'd0) begin
              scl_next = 1'b1;
            end else if (sub_step == 3'd2) begin
              shift_byte_next = cfg.lsb_first ? {item.sda_level, shift_byte[7:1]}
                                              : {shift_byte[6:0], item.sda_level};
              scl_next = 1'b0;
            end
            if (sub_step >= 3'd3) begin
              sub_step_next = '0;
              bit_index_next = bit_index + 4'd1;
            end else begin
              sub_step_next = sub_step + 3'd1;
            end
          end else begin
            if (sub_step == 3'd0) begin
              last = (word_index + 16'd1 == count_hold) &&
                     (byte_index + 3'd1 >= dlen);
              sda_next = last;
            end else if (sub_step == 3'd2) begin
              scl_next = 1'b1;
            end else if (sub_step == 3'd4) begin
              scl_next = 1'b0;
            end
            if (sub_step < 3'd5) begin
              sub_step_next = sub_step + 3'd1;
            end else begin
              if (byte_index < dlen) begin
                word_buffer_next = word_buffer |
                  ({24'd0, shift_byte} << bpos(byte_index, dlen, cfg.data_be));
              end
              bi = byte_index + 3'd1;
              do_go = 1'b1;
              tgt = PH_RDATA;
              byte_index_next = bi;
              if (bi >= dlen) begin
                valid_c = 1'b1;
                word_c = word_buffer_next;
                wi = word_index + 16'd1;
                word_index_next = wi;
                byte_index_next = '0;
                word_buffer_next = '0;
                if (wi == count_hold) begin
                  tgt = PH_STOP;
                end
              end
            end
          end
        end
        PH_HDR_W, PH_LO_W, PH_REG, PH_HDR_R, PH_WDATA: begin
          if (bit_index < 4'd8) begin
            if (sub_step == 3'd1) begin
              sel = cfg.lsb_first ? bit_index : (4'd7 - bit_index);
              sda_next = shift_byte[sel[2:0]];
            end else if (sub_step == 3'd3) begin
              scl_next = 1'b1;
            end else if (sub_step == 3'd5) begin
              scl_next = 1'b0;
            end
            if (sub_step >= 3'd5) begin
              sub_step_next = '0;
              bit_index_next = bit_index + 4'd1;
            end else begin
              sub_step_next = sub_step + 3'd1;
            end
          end else begin
            if (sub_step == 3'd0) begin
              sda_next = 1'b1;
            end else if (sub_step == 3'd2) begin
              scl_next = 1'b1;
            end else if (sub_step == 3'd4) begin
              if (item.sda_level) abort_flag_next = 1'b1;
              scl_next = 1'b0;
            end
            if (sub_step >= 3'd5) begin
              do_go = 1'b1;
              if (abort_flag) begin
                tgt = PH_STOP;
              end else begin
                case (phase)
                  PH_HDR_W, PH_LO_W: begin
                    if (phase == PH_HDR_W && cfg.ten_bit) begin
                      tgt = PH_LO_W;
                    end else if ((!is_read || cfg.dummy) && rlen != 3'd0) begin
                      byte_index_next = '0;
                      tgt = PH_REG;
                    end else if (is_read) begin
                      tgt = PH_RESTART;
                    end else begin
                      tgt = (count_hold == 16'd0) ? PH_STOP : PH_WAIT;
                    end
                  end
                  PH_REG: begin
                    bi = byte_index + 3'd1;
                    byte_index_next = bi;
                    if (bi >= rlen) begin
                      if (is_read) tgt = PH_RESTART;
                      else tgt = (count_hold == 16'd0) ? PH_STOP : PH_WAIT;
                    end else begin
                      tgt = PH_REG;
                    end
                  end
                  PH_HDR_R: begin
                    byte_index_next = '0;
                    word_buffer_next = '0;
                    tgt = (count_hold == 16'd0) ? PH_STOP : PH_RDATA;
                  end
                  default: begin
                    bi = byte_index + 3'd1;
                    byte_index_next = bi;
                    tgt = PH_WDATA;
                    if (bi >= dlen) begin
                      wi = word_index + 16'd1;
                      word_index_next = wi;
                      byte_index_next = '0;
                      tgt = (wi == count_hold) ? PH_STOP : PH_WAIT;
                    end
                  end
                endcase
              end
            end else begin
              sub_step_next = sub_step + 3'd1;
            end
          end
        end
        default: begin
          do_go = 1'b1;
          tgt = PH_IDLE;
        end
      endcase
    end
    if (do_go) begin
      phase_next = tgt;
      bit_index_next = '0;
      sub_step_next = '0;
      case (tgt)
        PH_HDR_W: shift_byte_next = header(cfg, 1'b0);
        PH_LO_W:  shift_byte_next = cfg.dev_addr[7:0];
        PH_HDR_R: shift_byte_next = header(cfg, 1'b1);
        PH_REG: begin
          i = (byte_index_next < rlen) ? byte_index_next : rlen - 3'd1;
          rbyte = 8'(address_hold_next >> bpos(i, rlen, cfg.reg_be));
          shift_byte_next = rbyte;
        end
        PH_WDATA: begin
          i = (byte_index_next < dlen) ? byte_index_next : dlen - 3'd1;
          shift_byte_next = 8'(word_buffer_next >> bpos(i, dlen, cfg.data_be));
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      bit_index <= '0;
      sub_step <= '0;
      byte_index <= '0;
      word_index <= '0;
      count_hold <= '0;
      shift_byte <= '0;
      word_buffer <= '0;
      address_hold <= '0;
      is_read <= 1'b0;
      abort_flag <= 1'b0;
      scl_pin <= 1'b1;
      sda_pin <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        phase <= phase_next;
        bit_index <= bit_index_next;
        sub_step <= sub_step_next;
        byte_index <= byte_index_next;
        word_index <= word_index_next;
        count_hold <= count_hold_next;
        shift_byte <= shift_byte_next;
        word_buffer <= word_buffer_next;
        address_hold <= address_hold_next;
        is_read <= is_read_next;
        abort_flag <= abort_flag_next;
        scl_pin <= scl_next;
        sda_pin <= sda_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res.scl_level <= scl_next;
      res.sda_drive <= sda_next;
      res.busy_res <= (phase_next != PH_IDLE);
      res.word_request <= (phase_next == PH_WAIT);
      res.read_word <= word_c;
      res.read_valid <= valid_c;
      res.done_res <= done_c;
      res.words_done <= word_index_next;
      res.nack_seen <= abort_flag_next;
    end
  end
endmodule
